/* sv/grid_cell_label_lookup_core_assert.svh */
// Assertion macros shared by the grid cell label lookup RTL.
`ifndef GRID_CELL_LABEL_LOOKUP_CORE_ASSERT_SVH
`define GRID_CELL_LABEL_LOOKUP_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// Checked outside reset.
`define GCLL_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");
// Checked at every edge, reset included.
`define GCLL_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");
`else
`define GCLL_ASSERT(name, clk, rst, prop)
`define GCLL_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

/* sv/gcll_pkg.sv */
// Types and constants of the grid cell label lookup.
package gcll_pkg;
  localparam int NDIM      = 3;
  localparam int COORD_W   = 32;
  localparam int GRID_W    = 13;
  localparam int QUOT_BITS = 13;
  localparam int NUM_W     = COORD_W + QUOT_BITS;
  localparam int PROD1_W   = 2 * GRID_W;
  localparam int PROD2_W   = 3 * GRID_W;
  localparam int IDX_W     = 3 * GRID_W + 1;
  localparam int TIDX_W    = 12;
  localparam int LVAL_W    = 16;
  localparam int FIFO_DEPTH = 32;
  localparam int FIFO_AW   = 5;
  localparam int CFG_IDX_W = 4;

  typedef enum logic [0:0] {
    OP_LOAD     = 1'b0,
    OP_CLASSIFY = 1'b1
  } op_t;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_COUNT = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_0   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_0   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_1   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_1   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_2   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_2   = 4'd7;

  typedef struct packed {
    logic zero;   // force cell 0
    logic last;   // force last cell
    logic flag;   // clamped or empty range
  } lane_tag_t;

  typedef struct packed {
    logic                    valid;
    op_t                     op;
    logic [TIDX_W-1:0]       tidx;
    logic [LVAL_W-1:0]       lval;
    lane_tag_t [NDIM-1:0]    lanes;
  } item_tag_t;

  typedef struct packed {
    logic [LVAL_W-1:0] label;
    logic [TIDX_W-1:0] cidx;
    logic              flag;
  } out_item_t;
endpackage

/* sv/gcll_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
module gcll_div (
  input  logic                          clk,
  input  logic [gcll_pkg::NUM_W-1:0]    num,
  input  logic [gcll_pkg::COORD_W-1:0]  den,
  output logic [gcll_pkg::QUOT_BITS-1:0] quot
);
  import gcll_pkg::*;

  logic [COORD_W-1:0]   rem_s [QUOT_BITS+1];
  logic [COORD_W-1:0]   den_s [QUOT_BITS+1];
  logic [QUOT_BITS-1:0] nlo_s [QUOT_BITS+1];
  logic [QUOT_BITS-1:0] q_s   [QUOT_BITS+1];

  // num < den * 2^QUOT_BITS, so the top part starts below den
  assign rem_s[0] = num[NUM_W-1:QUOT_BITS];
  assign den_s[0] = den;
  assign nlo_s[0] = num[QUOT_BITS-1:0];
  assign q_s[0]   = '0;

  for (genvar i = 0; i < QUOT_BITS; i++) begin : g_step
    logic [COORD_W:0] trial;
    logic [COORD_W:0] diff;
    logic             ge;
    always_comb begin
      trial = {rem_s[i], nlo_s[i][QUOT_BITS-1-i]};
      diff  = trial - {1'b0, den_s[i]};
      ge    = trial >= {1'b0, den_s[i]};
    end
    always_ff @(posedge clk) begin
      rem_s[i+1] <= ge ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
      den_s[i+1] <= den_s[i];
      nlo_s[i+1] <= nlo_s[i];
      q_s[i+1]   <= {q_s[i][QUOT_BITS-2:0], ge};
    end
  end

  assign quot = q_s[QUOT_BITS];
endmodule

/* sv/gcll_label_mem.sv */
// Label table: one synchronous port, write or registered read.
module gcll_label_mem #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 16,
  parameter int AW    = 12
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* sv/gcll_out_fifo.sv */
// Result queue between the pipeline and the output channel.
module gcll_out_fifo (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  gcll_pkg::out_item_t      din,
  input  logic                     pop,
  output logic                     valid,
  output gcll_pkg::out_item_t      dout,
  output logic [gcll_pkg::FIFO_AW:0] occ
);
  import gcll_pkg::*;

  out_item_t          buf_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr;
  logic [FIFO_AW-1:0] rptr;

  always_ff @(posedge clk) begin
    if (push) begin
      buf_q[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      occ  <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      occ <= occ + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
    end
  end

  assign valid = occ != '0;
  assign dout  = buf_q[rptr];
endmodule

/* sv/grid_cell_label_lookup_core.sv */
// Top level of the grid cell label lookup.
//
// Input channel (in_valid / in_stall) carries one item per accepted edge.
// A load item (operation 0) writes label_value into the label table at
// table_index; an index beyond the table is dropped. A classify item
// (operation 1) quantizes each active coordinate into a cell, builds the
// mixed-radix index (dimension zero least significant) and returns the
// stored label with cell_index and out_of_range on the output channel
// (out_valid / out_stall). Loads give no result.
// Throughput: one item per cycle while in_stall is low. Between the input
// accept and out_valid: the range check registers at the accept edge, then
// one multiply stage, a 13-stage divider (one quotient bit per stage), four
// index stages, the table read and the result queue write. Table writes
// happen at the read stage, in item order, so a classify sees exactly the
// loads accepted before it.
// A 32-entry result queue absorbs receiver stall; in_stall rises only when
// classify items in flight plus queued results fill the queue.
// Reset (rst, synchronous) restores the configuration defaults and empties
// the pipeline and the queue; the table keeps its contents and an entry
// must be loaded before it is classified. Config writes only while idle.
`include "grid_cell_label_lookup_core_assert.svh"
module grid_cell_label_lookup_core #(
  parameter int TABLE_DEPTH = 4096,
  parameter int LABEL_BITS  = 16,
  parameter int MAX_DIMS    = 3
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [gcll_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gcll_pkg::COORD_W-1:0]      cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              operation,
  input  logic signed [gcll_pkg::COORD_W-1:0] coord_0,
  input  logic signed [gcll_pkg::COORD_W-1:0] coord_1,
  input  logic signed [gcll_pkg::COORD_W-1:0] coord_2,
  input  logic [gcll_pkg::TIDX_W-1:0]       table_index,
  input  logic [gcll_pkg::LVAL_W-1:0]       label_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [gcll_pkg::LVAL_W-1:0]       label,
  output logic [gcll_pkg::TIDX_W-1:0]       cell_index,
  output logic                              out_of_range
);
  import gcll_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // ---- configuration registers ----
  logic [GRID_W-1:0]  grid_size;
  logic [1:0]         dim_count;
  logic [COORD_W-1:0] lower_bound [NDIM];
  logic [COORD_W-1:0] upper_bound [NDIM];

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= GRID_W'(16);
      dim_count <= 2'd2;
      for (int d = 0; d < NDIM; d++) begin
        lower_bound[d] <= '0;
        upper_bound[d] <= COORD_W'(65535);
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_SIZE: grid_size      <= cfg_data[GRID_W-1:0];
        REG_DIM_COUNT: dim_count      <= cfg_data[1:0];
        REG_LOWER_0:   lower_bound[0] <= cfg_data;
        REG_UPPER_0:   upper_bound[0] <= cfg_data;
        REG_LOWER_1:   lower_bound[1] <= cfg_data;
        REG_UPPER_1:   upper_bound[1] <= cfg_data;
        REG_LOWER_2:   lower_bound[2] <= cfg_data;
        REG_UPPER_2:   upper_bound[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective grid/dims: user keeps stable with items in flight; unchecked
  logic [GRID_W-1:0] g;
  logic [1:0]        n_eff;
  always_comb begin
    g = (grid_size == '0) ? GRID_W'(1) : grid_size;
    if (dim_count == 2'd0) begin
      n_eff = 2'd1;
    end else if (32'(dim_count) > MAX_DIMS) begin
      n_eff = 2'(MAX_DIMS);
    end else begin
      n_eff = dim_count;
    end
  end

  // ---- credit: classify items in flight plus queued results ----
  logic                 in_acc;
  logic                 out_acc;
  logic [FIFO_AW:0]     credit;
  logic [FIFO_AW:0]     occ;
  logic                 cls_acc;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign cls_acc  = in_acc && (operation == OP_CLASSIFY);
  assign in_stall = credit >= (FIFO_AW+1)'(FIFO_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
    end else begin
      credit <= credit + (FIFO_AW+1)'(cls_acc) - (FIFO_AW+1)'(out_acc);
    end
  end

  // ---- stage A: range checks, offset and span ----
  logic signed [COORD_W-1:0] coords [NDIM];
  assign coords[0] = coord_0;
  assign coords[1] = coord_1;
  assign coords[2] = coord_2;

  item_tag_t          a_tag;
  item_tag_t          a_tag_next;
  logic [COORD_W-1:0] a_off  [NDIM];
  logic [COORD_W-1:0] a_span [NDIM];
  logic [COORD_W-1:0] a_off_next  [NDIM];
  logic [COORD_W-1:0] a_span_next [NDIM];

  always_comb begin
    logic signed [COORD_W:0] x;
    logic signed [COORD_W:0] lo;
    logic signed [COORD_W:0] hi;
    logic signed [COORD_W:0] off;
    logic signed [COORD_W:0] span;
    logic act;
    logic empty;
    logic below;
    logic above;
    a_tag_next.valid = in_acc;
    a_tag_next.op    = op_t'(operation);
    a_tag_next.tidx  = table_index;
    a_tag_next.lval  = label_value;
    for (int d = 0; d < NDIM; d++) begin
      x     = {coords[d][COORD_W-1], coords[d]};
      lo    = {lower_bound[d][COORD_W-1], lower_bound[d]};
      hi    = {upper_bound[d][COORD_W-1], upper_bound[d]};
      off   = x - lo;
      span  = hi - lo;
      act   = 2'(d) < n_eff;
      empty = hi <= lo;
      below = x < lo;
      above = x > hi;
      a_tag_next.lanes[d].zero = !act || empty || below;
      a_tag_next.lanes[d].last = act && !empty && !below && above;
      a_tag_next.lanes[d].flag = act && (empty || below || above);
      a_off_next[d]  = off[COORD_W-1:0];
      a_span_next[d] = span[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_tag <= '0;
    end else begin
      a_tag <= a_tag_next;
    end
    a_off  <= a_off_next;
    a_span <= a_span_next;
  end

  // ---- stage B: offset times grid ----
  item_tag_t          b_tag;
  logic [NUM_W-1:0]   b_num  [NDIM];
  logic [COORD_W-1:0] b_span [NDIM];

  always_ff @(posedge clk) begin
    if (rst) begin
      b_tag <= '0;
    end else begin
      b_tag <= a_tag;
    end
    for (int d = 0; d < NDIM; d++) begin
      b_num[d]  <= NUM_W'(a_off[d]) * NUM_W'(g);
      b_span[d] <= a_span[d];
    end
  end

  // ---- dividers, tag line alongside ----
  logic [QUOT_BITS-1:0] quot [NDIM];
  item_tag_t            dl [QUOT_BITS];

  for (genvar d = 0; d < NDIM; d++) begin : g_div
    gcll_div u_div (
      .clk  (clk),
      .num  (b_num[d]),
      .den  (b_span[d]),
      .quot (quot[d])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QUOT_BITS; i++) begin
        dl[i] <= '0;
      end
    end else begin
      dl[0] <= b_tag;
      for (int i = 1; i < QUOT_BITS; i++) begin
        dl[i] <= dl[i-1];
      end
    end
  end

  // ---- stage C: cell per lane ----
  item_tag_t         c_tag;
  logic [GRID_W-1:0] c_cell [NDIM];
  logic              c_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_tag <= '0;
    end else begin
      c_tag <= dl[QUOT_BITS-1];
    end
    c_flag <= dl[QUOT_BITS-1].lanes[0].flag || dl[QUOT_BITS-1].lanes[1].flag ||
              dl[QUOT_BITS-1].lanes[2].flag;
    for (int d = 0; d < NDIM; d++) begin
      if (dl[QUOT_BITS-1].lanes[d].zero) begin
        c_cell[d] <= '0;
      end else if (dl[QUOT_BITS-1].lanes[d].last || quot[d] >= g) begin
        // coordinate on the upper bound lands in the last cell
        c_cell[d] <= g - 1'b1;
      end else begin
        c_cell[d] <= quot[d];
      end
    end
  end

  // ---- stage D: digit weights ----
  item_tag_t          d_tag;
  logic [GRID_W-1:0]  d_c0;
  logic [PROD1_W-1:0] d_m1;
  logic [PROD1_W-1:0] d_m2;
  logic               d_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_tag <= '0;
    end else begin
      d_tag <= c_tag;
    end
    d_c0   <= c_cell[0];
    d_m1   <= PROD1_W'(c_cell[1]) * PROD1_W'(g);
    d_m2   <= PROD1_W'(c_cell[2]) * PROD1_W'(g);
    d_flag <= c_flag;
  end

  // ---- stage E ----
  item_tag_t          e_tag;
  logic [PROD1_W:0]   e_s01;
  logic [PROD2_W-1:0] e_m2g;
  logic               e_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_tag <= '0;
    end else begin
      e_tag <= d_tag;
    end
    e_s01  <= (PROD1_W+1)'(d_c0) + (PROD1_W+1)'(d_m1);
    e_m2g  <= PROD2_W'(d_m2) * PROD2_W'(g);
    e_flag <= d_flag;
  end

  // ---- stage F: index, saturation, table address ----
  item_tag_t         f_tag;
  logic [AW-1:0]     f_addr;
  logic [TIDX_W-1:0] f_cidx;
  logic              f_flag;
  logic              f_we;
  logic [IDX_W-1:0]  idx_sum;
  logic [IDX_W-1:0]  idx_sat;
  logic              idx_over;

  always_comb begin
    idx_sum  = IDX_W'(e_s01) + IDX_W'(e_m2g);
    idx_over = idx_sum >= IDX_W'(TABLE_DEPTH);
    idx_sat  = idx_over ? IDX_W'(TABLE_DEPTH - 1) : idx_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_tag <= '0;
      f_we  <= 1'b0;
    end else begin
      f_tag <= e_tag;
      f_we  <= e_tag.valid && (e_tag.op == OP_LOAD) &&
               (32'(e_tag.tidx) < TABLE_DEPTH);
    end
    f_addr <= (e_tag.op == OP_LOAD) ? AW'(e_tag.tidx) : idx_sat[AW-1:0];
    f_cidx <= idx_sat[TIDX_W-1:0];
    f_flag <= e_flag || idx_over;
  end

  // ---- table access ----
  logic [LABEL_BITS-1:0] rdata;

  gcll_label_mem #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (LABEL_BITS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (f_we),
    .addr  (f_addr),
    .wdata (LABEL_BITS'(f_tag.lval)),
    .rdata (rdata)
  );

  logic              m_push;
  logic [TIDX_W-1:0] m_cidx;
  logic              m_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_push <= 1'b0;
    end else begin
      m_push <= f_tag.valid && (f_tag.op == OP_CLASSIFY);
    end
    m_cidx <= f_cidx;
    m_flag <= f_flag;
  end

  // ---- result queue ----
  out_item_t q_din;
  out_item_t q_dout;

  assign q_din.label = LVAL_W'(rdata);
  assign q_din.cidx  = m_cidx;
  assign q_din.flag  = m_flag;

  gcll_out_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (m_push),
    .din   (q_din),
    .pop   (out_acc),
    .valid (out_valid),
    .dout  (q_dout),
    .occ   (occ)
  );

  assign label        = q_dout.label;
  assign cell_index   = q_dout.cidx;
  assign out_of_range = q_dout.flag;

  // ---- checks ----
  `GCLL_ASSERT(a_credit_bound, clk, rst, credit <= (FIFO_AW+1)'(FIFO_DEPTH))
  `GCLL_ASSERT(a_push_has_credit, clk, rst, m_push |-> (credit > occ))
  `GCLL_ASSERT(a_queue_within_credit, clk, rst, occ <= credit)
  `GCLL_ASSERT_ALWAYS(a_empty_after_reset, clk, rst |=> !out_valid)
endmodule
